// ----- sv/url_percent_codec_core_assert.svh -----
// Assertion macros used by the checker file.
`ifndef URL_PERCENT_CODEC_CORE_ASSERT_SVH
`define URL_PERCENT_CODEC_CORE_ASSERT_SVH

// Same-cycle implication, masked while reset is active.
`define UPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is active.
`define UPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define UPC_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/upc_pkg.sv -----
package upc_pkg;

  // Queue depth between the classifier and the emitter.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEX_LOWERCASE = 1'b1;

  // Character codes and hex digit offsets.
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_PERCENT    = 8'h25;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TILDE      = 8'h7E;
  localparam logic [7:0] CH_DASH       = 8'h2D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] DIGIT_OFS     = 8'd48;
  localparam logic [7:0] UPPER_OFS     = 8'd55;
  localparam logic [7:0] LOWER_OFS     = 8'd87;

  // Marks a byte that is no hex digit.
  localparam logic [4:0] HEX_NONE = 5'd16;

  // Decoder escape progress.
  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_phase_t;

  // Configuration register contents.
  typedef struct packed {
    logic decode_mode;
    logic hex_lowercase;
  } cfg_t;

  // One classified item: either a single result beat, or a three-beat
  // escape whose first byte is b0 and whose last beat carries the end mark.
  typedef struct packed {
    logic       wide;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       last;
    logic       err;
  } job_t;

endpackage

// ----- sv/upc_ifs.sv -----
// Input byte channel.
interface upc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Result byte channel.
interface upc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_error;

  modport source (output valid, output out_byte, output out_last, output out_error,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input out_error,
                  output ready);
endinterface

// Configuration write channel.
interface upc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [upc_pkg::CFG_IDX_W-1:0]  index;
  logic                           data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/url_percent_codec_core.sv -----
// Channel   Dir  Beat contents
// in_ch     in   in_byte, in_last (one raw byte)
// out_ch    out  out_byte, out_last, out_error (one converted byte)
// cfg_ch    in   index, data (one register write)
//
// A byte is taken every cycle while the job queue has room; the classifier
// keeps the decoder escape state and hands one job per result-producing byte.
// The emitter sends 1 beat per job, or 3 for an escaped encoder byte, from the
// single output register. Reset (rst_n low, synchronous) clears the queue,
// escape state and registers. Stalls on out_ch fill the queue, after which
// in_ch.ready drops.
module url_percent_codec_core #(
  parameter int QUEUE_DEPTH = upc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  upc_in_if.sink     in_ch,
  upc_out_if.source  out_ch,
  upc_cfg_if.sink    cfg_ch
);

  upc_pkg::cfg_t cfg_r, cfg_nxt;
  upc_pkg::job_t push_job, pop_job;
  logic          q_push, q_full, q_pop, q_empty;

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        upc_pkg::REG_DECODE_MODE:   cfg_nxt.decode_mode   = cfg_ch.data;
        upc_pkg::REG_HEX_LOWERCASE: cfg_nxt.hex_lowercase = cfg_ch.data;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else cfg_r <= cfg_nxt;
  end

  upc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  upc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  upc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- sv/upc_front.sv -----
module upc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  upc_pkg::cfg_t  cfg,
  upc_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           q_push,
  output upc_pkg::job_t  q_job
);

  upc_pkg::esc_phase_t phase_r, phase_nxt;
  logic [3:0]          nib_r, nib_nxt;
  logic                fire;
  logic                job_valid;
  logic [4:0]          dig;
  logic [7:0]          c;

  // Value of a hex digit, or the no-digit mark.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = upc_pkg::HEX_NONE;
    if (b >= 8'h30 && b <= 8'h39) v = 5'(b - upc_pkg::DIGIT_OFS);
    else if (b >= 8'h41 && b <= 8'h46) v = 5'(b - upc_pkg::UPPER_OFS);
    else if (b >= 8'h61 && b <= 8'h66) v = 5'(b - upc_pkg::LOWER_OFS);
    return v;
  endfunction

  // ASCII character for one nibble.
  function automatic logic [7:0] nibble_char(input logic [3:0] v, input logic lower);
    logic [7:0] r;
    if (v > 4'd9) r = {4'd0, v} + (lower ? upc_pkg::LOWER_OFS : upc_pkg::UPPER_OFS);
    else r = {4'd0, v} + upc_pkg::DIGIT_OFS;
    return r;
  endfunction

  // Unreserved characters that the encoder passes as they are.
  function automatic logic passes_plain(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || b == upc_pkg::CH_DASH ||
           b == upc_pkg::CH_UNDERSCORE || b == upc_pkg::CH_DOT ||
           b == upc_pkg::CH_TILDE;
  endfunction

  assign c           = in_ch.in_byte;
  assign dig         = hex_value(c);
  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign q_push      = fire && job_valid;

  // Escape tracking for the decoder.
  always_comb begin
    phase_nxt = upc_pkg::ESC_IDLE;
    nib_nxt   = '0;
    if (!fire) begin
      phase_nxt = phase_r;
      nib_nxt   = nib_r;
    end else if (cfg.decode_mode) begin
      unique case (phase_r)
        upc_pkg::ESC_HIGH: begin
          if (!dig[4] && !in_ch.in_last) begin
            phase_nxt = upc_pkg::ESC_LOW;
            nib_nxt   = dig[3:0];
          end
        end
        upc_pkg::ESC_LOW: phase_nxt = upc_pkg::ESC_IDLE;
        default: begin
          if (c == upc_pkg::CH_PERCENT && !in_ch.in_last) phase_nxt = upc_pkg::ESC_HIGH;
        end
      endcase
    end
  end

  // Classify the beat into the job for the emitter.
  always_comb begin
    q_job      = '0;
    q_job.last = in_ch.in_last;
    job_valid  = 1'b1;
    if (!cfg.decode_mode) begin
      if (passes_plain(c)) begin
        q_job.b0 = c;
      end else if (c == upc_pkg::CH_SPACE) begin
        q_job.b0 = upc_pkg::CH_PLUS;
      end else begin
        q_job.wide = 1'b1;
        q_job.b0   = upc_pkg::CH_PERCENT;
        q_job.b1   = nibble_char(c[7:4], cfg.hex_lowercase);
        q_job.b2   = nibble_char(c[3:0], cfg.hex_lowercase);
      end
    end else begin
      unique case (phase_r)
        upc_pkg::ESC_HIGH: begin
          // A bad digit or a cut-off escape reports an error; otherwise wait.
          if (dig[4] || in_ch.in_last) q_job.err = 1'b1;
          else job_valid = 1'b0;
        end
        upc_pkg::ESC_LOW: begin
          if (dig[4]) q_job.err = 1'b1;
          else q_job.b0 = {nib_r, dig[3:0]};
        end
        default: begin
          if (c == upc_pkg::CH_PLUS) begin
            q_job.b0 = upc_pkg::CH_SPACE;
          end else if (c == upc_pkg::CH_PERCENT) begin
            if (in_ch.in_last) q_job.err = 1'b1;
            else job_valid = 1'b0;
          end else begin
            q_job.b0 = c;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= upc_pkg::ESC_IDLE;
      nib_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      nib_r   <= nib_nxt;
    end
  end

endmodule

// ----- sv/upc_queue.sv -----
module upc_queue #(
  parameter int DEPTH = upc_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  upc_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output upc_pkg::job_t  pop_job,
  output logic           empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  upc_pkg::job_t     slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slot_r[rd_ptr_r];

  // Pointer wrap and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- sv/upc_back.sv -----
module upc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  upc_pkg::job_t  q_job,
  output logic           q_pop,
  upc_out_if.source      out_ch
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;
  logic       err_r, err_nxt;
  logic       load;
  logic       final_beat;

  // The output register takes a new beat when it is empty or being drained.
  assign load       = !q_empty && (!out_valid_r || out_ch.ready);
  assign final_beat = !q_job.wide || (idx_r == 2'd2);
  assign q_pop      = load && final_beat;

  // Pick the beat of the current job.
  always_comb begin
    case (idx_r)
      2'd1:    byte_nxt = q_job.b1;
      2'd2:    byte_nxt = q_job.b2;
      default: byte_nxt = q_job.b0;
    endcase
    last_nxt = final_beat && q_job.last;
    err_nxt  = q_job.err;
  end

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (load) begin
      idx_nxt       = final_beat ? 2'd0 : idx_r + 2'd1;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      last_r <= last_nxt;
      err_r  <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = byte_r;
  assign out_ch.out_last  = last_r;
  assign out_ch.out_error = err_r;

endmodule

// ----- sv/upc_checker.sv -----
`include "url_percent_codec_core_assert.svh"

module upc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [7:0]                    out_byte,
  input logic                          out_last,
  input logic                          out_error,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [upc_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic                          cfg_data
);

  logic decode_r;

  // Mode as seen on the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) decode_r <= 1'b0;
    else if (cfg_valid && cfg_ready && cfg_index == upc_pkg::REG_DECODE_MODE)
      decode_r <= cfg_data;
  end

  // Reset leaves no beat pending on the result side.
  `UPC_ASSERT_RST(a_reset_idle, !rst_n, !out_valid, "result beat valid after reset")

  // A stalled result beat keeps its contents.
  `UPC_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
    out_valid && $stable(out_byte) && $stable(out_last) && $stable(out_error),
    "stalled result beat changed")

  // Errors come only from the decoder.
  `UPC_ASSERT_NOW(a_err_decode, out_valid && out_error, decode_r,
    "error beat while encoding")

  // An error beat carries a zero byte.
  `UPC_ASSERT_NOW(a_err_zero, out_valid && out_error, out_byte == 8'd0,
    "error beat with nonzero byte")

endmodule

bind url_percent_codec_core upc_checker u_upc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.out_last),
  .out_error (out_ch.out_error),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready),
  .cfg_index (cfg_ch.index),
  .cfg_data  (cfg_ch.data)
);
